// ===== src/bship_pkg.sv =====
package bship_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_VIEW_W   = 3'd0;
    localparam logic [2:0] REG_VIEW_H   = 3'd1;
    localparam logic [2:0] REG_ZOOM     = 3'd2;
    localparam logic [2:0] REG_OFF_RE   = 3'd3;
    localparam logic [2:0] REG_OFF_IM   = 3'd4;
    localparam logic [2:0] REG_MAX_ITER = 3'd5;

    // fixed point: products are shifted right by this many bits
    localparam int Q_SHIFT = 28;

    // mapping divider: numerator is scaled offset shifted up by NUM_LO bits
    localparam int SM_W   = 14;
    localparam int NUM_LO = 44;
    localparam int NUM_W  = SM_W + NUM_LO;
    localparam int DEN_W  = 45;
    localparam int QUO_W  = 31;

    // escape threshold, 4.0 in q8.28
    localparam logic [35:0] ESCAPE_LIM = 36'h0_4000_0000;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } t_in_word;

    typedef struct packed {
        logic [15:0] iteration_count;
        logic [39:0] magnitude_sq;
    } t_out_word;

    // divider status towards the sequencer
    typedef struct packed {
        logic             done;
        logic             big;
        logic [QUO_W-1:0] quot;
    } t_div_res;

endpackage

// ===== src/burning_ship_escape_time_unit.sv =====
// each axis mapping runs through the bit-serial divider
// each iteration runs on the one shared 32x32 multiplier
// a new pixel word is taken only when idle; a stalled result holds the block in S_FIN
// reset: synchronous active low, clears control and loads register defaults
module burning_ship_escape_time_unit import bship_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEN    = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_ITER   = 4'd4;
    localparam logic [3:0] S_UPD    = 4'd5;
    localparam logic [3:0] S_SQRE   = 4'd6;
    localparam logic [3:0] S_SQIM   = 4'd7;
    localparam logic [3:0] S_CHK    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] res;
        if (v > 38'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -38'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // configuration registers
    logic [12:0] r_view_w, r_view_h;
    logic [31:0] r_zoom, r_off_re, r_off_im;
    logic [15:0] r_max_iter;

    logic [3:0]  r_state, n_state;
    logic        r_axis, n_axis;
    logic [11:0] r_px, n_px, r_py, n_py;
    logic        r_neg, n_neg;
    logic        r_sm_zero, n_sm_zero;
    logic [31:0] r_cre, n_cre, r_cim, n_cim;
    logic [31:0] r_re, n_re, r_im, n_im;
    logic [34:0] r_sr, n_sr, r_si, n_si;
    logic [15:0] r_iter, n_iter;
    logic [35:0] r_mag, n_mag;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic [12:0]        dim_w, dim_h, cur_dim;
    logic [11:0]        cur_p;
    logic signed [13:0] diff;
    logic               neg;
    logic [12:0]        amag;
    logic [SM_W-1:0]    sm;
    logic               div_start;
    t_div_res           div_res;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic [34:0]        prod_q;
    logic [31:0]        abs_re, abs_im, cur_off;
    logic signed [32:0] q_signed;
    logic [31:0]        c_new;
    logic [35:0]        mag_new;
    logic [31:0]        nre, nim;

    // configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w   <= 13'd800;
            r_view_h   <= 13'd800;
            r_zoom     <= 32'd65536;
            r_off_re   <= '0;
            r_off_im   <= '0;
            r_max_iter <= 16'd50;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VIEW_W:   r_view_w   <= i_cfg_data[12:0];
                REG_VIEW_H:   r_view_h   <= i_cfg_data[12:0];
                REG_ZOOM:     r_zoom     <= i_cfg_data;
                REG_OFF_RE:   r_off_re   <= i_cfg_data;
                REG_OFF_IM:   r_off_im   <= i_cfg_data;
                REG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-axis mapping terms
    assign dim_w   = (int'(r_view_w) > MAX_DIM) ? 13'(MAX_DIM) : r_view_w;
    assign dim_h   = (int'(r_view_h) > MAX_DIM) ? 13'(MAX_DIM) : r_view_h;
    assign cur_dim = r_axis ? dim_h : dim_w;
    assign cur_p   = r_axis ? r_py : r_px;
    assign cur_off = r_axis ? r_off_im : r_off_re;
    assign diff    = $signed({2'b00, cur_p}) - $signed({2'b00, cur_dim[12:1]});
    assign neg     = diff[13];
    assign amag    = neg ? 13'(-diff) : diff[12:0];
    // real axis scale 3, imaginary axis scale 2
    assign sm      = r_axis ? {amag, 1'b0} : ({1'b0, amag} + {amag, 1'b0});

    // signed, saturated quotient plus pan offset
    always_comb begin
        if (r_sm_zero) begin
            q_signed = '0;
        end else if (div_res.big) begin
            q_signed = r_neg ? 33'sh1_8000_0000 : 33'sh0_7FFF_FFFF;
        end else if (r_neg) begin
            q_signed = -$signed({2'b00, div_res.quot});
        end else begin
            q_signed = $signed({2'b00, div_res.quot});
        end
        c_new = sat32(38'(q_signed) + 38'($signed(cur_off)));
    end

    // operands of the shared multiplier
    assign abs_re = r_re[31] ? (~r_re + 32'd1) : r_re;
    assign abs_im = r_im[31] ? (~r_im + 32'd1) : r_im;

    always_comb begin
        case (r_state)
            S_DEN: begin
                mul_a = r_zoom;
                mul_b = {19'd0, cur_dim};
            end
            S_ITER: begin
                mul_a = abs_re;
                mul_b = abs_im;
            end
            S_SQRE: begin
                mul_a = abs_re;
                mul_b = abs_re;
            end
            S_SQIM: begin
                mul_a = abs_im;
                mul_b = abs_im;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bship_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    bship_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sm    (sm),
        .i_den   (prod[DEN_W-1:0]),
        .o_res   (div_res)
    );

    // iteration arithmetic
    assign prod_q  = prod[62:Q_SHIFT];
    assign nre     = sat32($signed({3'b000, r_sr}) - $signed({3'b000, r_si})
                           + 38'($signed(r_cre)));
    assign nim     = sat32($signed({2'b00, prod_q, 1'b0}) + 38'($signed(r_cim)));
    assign mag_new = {1'b0, r_sr} + {1'b0, prod_q};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_px        = r_px;
        n_py        = r_py;
        n_neg       = r_neg;
        n_sm_zero   = r_sm_zero;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_re        = r_re;
        n_im        = r_im;
        n_sr        = r_sr;
        n_si        = r_si;
        n_iter      = r_iter;
        n_mag       = r_mag;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_px    = i_in_data.pixel_x;
                    n_py    = i_in_data.pixel_y;
                    n_axis  = 1'b0;
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_neg     = neg;
                n_sm_zero = (sm == '0);
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_res.done) begin
                    if (!r_axis) begin
                        n_cre   = c_new;
                        n_axis  = 1'b1;
                        n_state = S_DEN;
                    end else begin
                        n_cim   = c_new;
                        n_re    = '0;
                        n_im    = '0;
                        n_sr    = '0;
                        n_si    = '0;
                        n_iter  = '0;
                        n_mag   = '0;
                        n_state = S_ITER;
                    end
                end
            end
            S_ITER: begin
                n_state = (r_iter < r_max_iter) ? S_UPD : S_FIN;
            end
            S_UPD: begin
                n_re    = nre;
                n_im    = nim;
                n_state = S_SQRE;
            end
            S_SQRE: begin
                n_state = S_SQIM;
            end
            S_SQIM: begin
                n_sr    = prod_q;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_si  = prod_q;
                n_mag = mag_new;
                if (mag_new > ESCAPE_LIM) begin
                    n_state = S_FIN;
                end else begin
                    n_iter  = r_iter + 16'd1;
                    n_state = S_ITER;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.iteration_count = r_iter;
                    n_out.magnitude_sq    = {4'd0, r_mag};
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
        r_px      <= n_px;
        r_py      <= n_py;
        r_neg     <= n_neg;
        r_sm_zero <= n_sm_zero;
        r_cre     <= n_cre;
        r_cim     <= n_cim;
        r_re      <= n_re;
        r_im      <= n_im;
        r_sr      <= n_sr;
        r_si      <= n_si;
        r_iter    <= n_iter;
        r_mag     <= n_mag;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/bship_mul.sv =====
module bship_mul import bship_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    // shared unsigned multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/bship_div.sv =====
module bship_div import bship_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SM_W-1:0]  i_sm,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [QUO_W-1:0] r_quot, n_quot;
    logic             r_big, n_big;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit a cycle
    always_comb begin
        trial  = {r_rem, r_num[NUM_W-1]};
        fits   = trial >= {1'b0, r_den};
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_big  = r_big;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = {i_sm, {NUM_LO{1'b0}}};
            n_rem  = '0;
            n_den  = i_den;
            n_quot = '0;
            n_big  = 1'b0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num  = r_num << 1;
            n_rem  = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quot = {r_quot[QUO_W-2:0], fits};
            // sticky flag for quotient bits at or above 2^31
            n_big  = r_big | r_quot[QUO_W-1];
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
        r_big  <= n_big;
    end

    assign o_res = '{done: r_done, big: r_big, quot: r_quot};

endmodule

// ===== src/bship_checker.sv =====
module bship_checker import bship_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_word    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_word   o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    // a taken pixel word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken but block not busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // squared magnitude of two saturated q4.28 values stays below 2^36
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.magnitude_sq[39:36] == 4'd0))
        else $error("magnitude out of range");

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind burning_ship_escape_time_unit bship_checker u_chk (.*);

// ===== bench/escape_checker.sv =====
`timescale 1ns / 1ps

// watches the pixel, result and register channels, predicts each result word
// and compares it with what the block returns
module escape_checker import bship_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_words_pending
);

    localparam longint INT_TOP = 64'sd2147483647;
    localparam longint INT_BOT = -64'sd2147483648;
    localparam logic [63:0] MAG_TOP = 64'h00FF_FFFF_FFFF;
    localparam logic [63:0] QUOT_TOP = 64'h1_0000_0000;

    // view registers as the block should hold them
    logic [12:0] view_w;
    logic [12:0] view_h;
    logic [31:0] zoom;
    int          off_re;
    int          off_im;
    logic [15:0] iter_limit;

    // state left behind by the last pixel
    int          z_re_last;
    int          z_im_last;
    int          c_re_last;
    int          c_im_last;
    logic [15:0] count_last;

    t_out_word   expected_q[$];
    int          fail_count = 0;
    int          words_checked = 0;

    function automatic int clip32(input longint v);
        if (v > INT_TOP) return int'(INT_TOP);
        if (v < INT_BOT) return int'(INT_BOT);
        return int'(v);
    endfunction

    function automatic logic [63:0] abs_wide(input int v);
        longint w;
        w = v;
        if (w < 0) w = -w;
        return 64'(w);
    endfunction

    // pixel to q4.28 along one axis, offset added with saturation
    function automatic int map_axis(input logic [11:0] p, input logic [12:0] dim,
                                    input logic [1:0] scale, input int off);
        logic [12:0] d;
        longint      diff;
        longint      q;
        logic [63:0] span;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        logic        neg;
        d = (int'(dim) > MAX_DIM) ? 13'(MAX_DIM) : dim;
        diff = longint'({52'd0, p}) - longint'({52'd0, d[12:1]});
        neg = diff < 0;
        span = neg ? 64'(-diff) : 64'(diff);
        num = ({62'd0, scale} * span) << NUM_LO;
        den = {32'd0, zoom} * {51'd0, d};
        if (den == 64'd0) begin
            if (num == 64'd0) q = 0;
            else q = neg ? INT_BOT : INT_TOP;
        end else begin
            quot = num / den;
            if (quot > QUOT_TOP) quot = QUOT_TOP;
            q = neg ? -longint'(quot) : longint'(quot);
        end
        return clip32(longint'(clip32(q)) + longint'(off));
    endfunction

    // escape count and final |z|^2 for one pixel
    function automatic t_out_word escape_time(input logic [11:0] px, input logic [11:0] py);
        int          c_re;
        int          c_im;
        int          re;
        int          im;
        int          nre;
        int          nim;
        logic [63:0] ar;
        logic [63:0] ai;
        logic [63:0] nr;
        logic [63:0] ni;
        logic [63:0] mag;
        longint      sr;
        longint      si;
        longint      cr;
        int          n;
        logic        escaped;
        t_out_word   res;
        c_re = map_axis(px, view_w, 2'd3, off_re);
        c_im = map_axis(py, view_h, 2'd2, off_im);
        re = 0;
        im = 0;
        mag = 64'd0;
        n = 0;
        escaped = 1'b0;
        while (n < int'(iter_limit) && !escaped) begin
            ar = abs_wide(re);
            ai = abs_wide(im);
            sr = longint'((ar * ar) >> Q_SHIFT);
            si = longint'((ai * ai) >> Q_SHIFT);
            cr = longint'((ar * ai) >> Q_SHIFT);
            nre = clip32(sr - si + longint'(c_re));
            nim = clip32(2 * cr + longint'(c_im));
            nr = abs_wide(nre);
            ni = abs_wide(nim);
            mag = ((nr * nr) >> Q_SHIFT) + ((ni * ni) >> Q_SHIFT);
            if (mag > MAG_TOP) mag = MAG_TOP;
            re = nre;
            im = nim;
            if (mag > 64'(ESCAPE_LIM)) escaped = 1'b1;
            else n++;
        end
        z_re_last = re;
        z_im_last = im;
        c_re_last = c_re;
        c_im_last = c_im;
        count_last = n[15:0];
        res.iteration_count = n[15:0];
        res.magnitude_sq = mag[39:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // register writes, new pixels and returned words, all sampled at the edge
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            view_w = 13'd800;
            view_h = 13'd800;
            zoom = 32'd65536;
            off_re = 0;
            off_im = 0;
            iter_limit = 16'd50;
            z_re_last = 0;
            z_im_last = 0;
            c_re_last = 0;
            c_im_last = 0;
            count_last = 16'd0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_VIEW_W:   view_w = i_cfg_data[12:0];
                    REG_VIEW_H:   view_h = i_cfg_data[12:0];
                    REG_ZOOM:     zoom = i_cfg_data;
                    REG_OFF_RE:   off_re = int'(i_cfg_data);
                    REG_OFF_IM:   off_im = int'(i_cfg_data);
                    REG_MAX_ITER: iter_limit = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(escape_time(i_in_data.pixel_x, i_in_data.pixel_y));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result word %0d arrived with nothing pending",
                                              words_checked));
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_data.iteration_count !== want.iteration_count)
                        report_mismatch($sformatf("word %0d iteration_count %0d, expected %0d",
                                                  words_checked, i_out_data.iteration_count,
                                                  want.iteration_count));
                    if (i_out_data.magnitude_sq !== want.magnitude_sq)
                        report_mismatch($sformatf("word %0d magnitude_sq %h, expected %h",
                                                  words_checked, i_out_data.magnitude_sq,
                                                  want.magnitude_sq));
                end
                words_checked++;
            end
        end
        o_words_pending <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bship_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 3000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_VIEW_W;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          words_pending;

    // idling switches, changed between phases
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          hold_request = 1'b0;
    int          cycle_count = 0;

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    burning_ship_escape_time_unit #(.MAX_DIM(4096)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    escape_checker #(.MAX_DIM(4096)) pixel_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // offer one pixel word after a random gap and wait for it to be taken
    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.pixel_x <= x;
        in_data.pixel_y <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop offering and wait until every result word is back
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one register write, valid left high for the next one
    task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_view(input logic [12:0] w, input logic [12:0] h,
                             input logic [31:0] zm, input logic [31:0] ore,
                             input logic [31:0] oim, input logic [15:0] iters);
        put_reg(REG_VIEW_W, {19'd0, w});
        put_reg(REG_VIEW_H, {19'd0, h});
        put_reg(REG_ZOOM, zm);
        put_reg(REG_OFF_RE, ore);
        put_reg(REG_OFF_IM, oim);
        put_reg(REG_MAX_ITER, {16'd0, iters});
        cfg_valid <= 1'b0;
    endtask

    // mostly inside the view, sometimes anywhere in the field
    function automatic logic [11:0] pick_pixel(input logic [12:0] dim);
        int top;
        top = (dim == 13'd0 || dim > 13'd4096) ? 4095 : int'(dim) - 1;
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return 12'($urandom_range(0, top));
    endfunction

    // result side: random stall per word, one long hold on request
    initial begin : receiver
        int n;
        forever begin
            if (hold_request) begin
                n = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                n = stalls_on ? $urandom_range(0, 5) : 0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("burning_ship_escape_time_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          k;
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] zm;
        logic [31:0] ore;
        logic [31:0] oim;
        logic [15:0] iters;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, centre (never escapes), alternating bits
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd400, 12'd400);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd799, 12'd0);

        // width above the bound, zero height divisor
        drain_block();
        load_view(13'd8191, 13'd0, 32'd65536, 32'd0, 32'd0, 16'd20);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd100, 12'd4095);

        // zero zoom: divisor zero with negative, zero and positive numerators
        drain_block();
        load_view(13'd2, 13'd3, 32'd0, 32'd0, 32'd0, 16'd10);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd4095);

        // smallest zoom and size: quotient clamped
        drain_block();
        load_view(13'd1, 13'd1, 32'd1, 32'd0, 32'd0, 16'd5);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // zero iteration limit
        drain_block();
        load_view(13'd800, 13'd800, 32'd65536, 32'd0, 32'd0, 16'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd400, 12'd400);

        // largest zoom and limit, offsets at both ends, sums saturating
        drain_block();
        load_view(13'd4096, 13'd4096, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        drain_block();
        load_view(13'd4096, 13'd4096, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // random views, each phase with its own idling mix
        for (phase = 0; phase < 14; phase++) begin
            drain_block();
            case ($urandom_range(0, 9))
                0: w = 13'($urandom_range(4097, 8191));
                1: w = 13'($urandom_range(1, 16));
                default: w = 13'($urandom_range(16, 4096));
            endcase
            case ($urandom_range(0, 9))
                0: h = 13'($urandom_range(4097, 8191));
                1: h = 13'($urandom_range(1, 16));
                default: h = 13'($urandom_range(16, 4096));
            endcase
            zm = ($urandom_range(0, 4) == 0) ? $urandom
                                              : $urandom_range(32'h0000_8000, 32'h0040_0000);
            ore = ($urandom_range(0, 4) == 0) ? $urandom
                                               : $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
            oim = ($urandom_range(0, 4) == 0) ? $urandom
                                               : $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
            iters = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(33, 64))
                                                 : 16'($urandom_range(1, 32));
            load_view(w, h, zm, ore, oim, iters);
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            // result side held off while pixels keep coming
            if (phase == 3) hold_request = 1'b1;
            for (k = 0; k < 100; k++) begin
                // sender pause until everything is back
                if (phase == 6 && k == 50) drain_block();
                send_pixel(pick_pixel(w), pick_pixel(h));
            end
        end

        drain_block();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("burning_ship_escape_time_unit verification clean");
        else
            $display("burning_ship_escape_time_unit verification failed");
        $finish;
    end

endmodule
